FILE: rtl/morse_keyer_farnsworth_defines.svh
// ----------------------------------------------------------------------------
// Morse keyer assertion macros
// Shared property forms for the checker of the Morse keyer.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEYER_FARNSWORTH_DEFINES_SVH
`define MORSE_KEYER_FARNSWORTH_DEFINES_SVH

// consequent checked on the same edge as the antecedent
`define MKF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked on the edge after the antecedent
`define MKF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mkf_pkg.sv
// ----------------------------------------------------------------------------
// Morse keyer package
// Types, timing tables and the character lookup of the Morse keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package mkf_pkg;

   localparam int WPM_W   = 8;
   localparam int COMP_W  = 16;
   localparam int DOT_W   = 8;
   localparam int UNIT_W  = 10;
   localparam int DIFF_W  = 14;
   localparam int T37_W   = 13;
   localparam int DUR_W   = 17;
   localparam int IDX_W   = 6;
   localparam int TAB_LEN = 36;
   localparam int DASH_W  = 6;
   localparam int ELEM_W  = 3;
   localparam int PROD_W  = 28;

   localparam logic [WPM_W-1:0] WPM_MIN = 8'd5;
   localparam logic [WPM_W-1:0] WPM_MAX = 8'd40;

   localparam logic [WPM_W-1:0]  CHAR_SPEED_RST = 8'd18;
   localparam logic [WPM_W-1:0]  EFF_SPEED_RST  = 8'd12;
   localparam logic [COMP_W-1:0] KEY_COMP_RST   = 16'd0;

   // floor(x/19) = (x * 13798) >> 18 for x < 12001
   localparam logic [DIFF_W-1:0] RECIP_19    = 14'd13798;
   localparam int                RECIP_SHIFT = 18;

   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [2:0] SETTLE_CYCLES = 3'd5;

   typedef enum logic [1:0] {
      CSR_CHAR_SPEED = 2'd0,
      CSR_EFF_SPEED  = 2'd1,
      CSR_KEY_COMP   = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      KIND_KNOWN   = 2'd0,
      KIND_SPACE   = 2'd1,
      KIND_UNKNOWN = 2'd2
   } kind_type;

   // dash bits left-aligned: element 0 at the top bit, 1 = dash
   typedef struct packed {
      kind_type              kind;
      logic [ELEM_W-1:0]     len;
      logic [DASH_W-1:0]     dash;
   } desc_type;

   typedef struct packed {
      logic                  ok;
      logic [DOT_W-1:0]      dot;
      logic [UNIT_W-1:0]     unit;
   } timing_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'd0,
      BK_MARK  = 3'd1,
      BK_SPACE = 3'd2,
      BK_END   = 3'd3,
      BK_WORD  = 3'd4
   } back_state_type;

   // 1200 / wpm, indexed by wpm - 5
   localparam logic [DOT_W-1:0] DOT_TAB [0:TAB_LEN-1] = '{
      8'd240, 8'd200, 8'd171, 8'd150, 8'd133, 8'd120, 8'd109, 8'd100, 8'd92,
      8'd85,  8'd80,  8'd75,  8'd70,  8'd66,  8'd63,  8'd60,  8'd57,  8'd54,
      8'd52,  8'd50,  8'd48,  8'd46,  8'd44,  8'd42,  8'd41,  8'd40,  8'd38,
      8'd37,  8'd36,  8'd35,  8'd34,  8'd33,  8'd32,  8'd31,  8'd30,  8'd30
   };

   // 60000 / wpm, indexed by wpm - 5
   localparam logic [DIFF_W-1:0] SIXTY_TAB [0:TAB_LEN-1] = '{
      14'd12000, 14'd10000, 14'd8571, 14'd7500, 14'd6666, 14'd6000, 14'd5454,
      14'd5000,  14'd4615,  14'd4285, 14'd4000, 14'd3750, 14'd3529, 14'd3333,
      14'd3157,  14'd3000,  14'd2857, 14'd2727, 14'd2608, 14'd2500, 14'd2400,
      14'd2307,  14'd2222,  14'd2142, 14'd2068, 14'd2000, 14'd1935, 14'd1875,
      14'd1818,  14'd1764,  14'd1714, 14'd1666, 14'd1621, 14'd1578, 14'd1538,
      14'd1500
   };

   // 37200 / wpm, indexed by wpm - 5
   localparam logic [T37_W-1:0] T37_TAB [0:TAB_LEN-1] = '{
      13'd7440, 13'd6200, 13'd5314, 13'd4650, 13'd4133, 13'd3720, 13'd3381,
      13'd3100, 13'd2861, 13'd2657, 13'd2480, 13'd2325, 13'd2188, 13'd2066,
      13'd1957, 13'd1860, 13'd1771, 13'd1690, 13'd1617, 13'd1550, 13'd1488,
      13'd1430, 13'd1377, 13'd1328, 13'd1282, 13'd1240, 13'd1200, 13'd1162,
      13'd1127, 13'd1094, 13'd1062, 13'd1033, 13'd1005, 13'd978,  13'd953,
      13'd930
   };

   function automatic desc_type known(input logic [ELEM_W-1:0] n,
                                      input logic [DASH_W-1:0] p);
      desc_type d;
      d.kind = KIND_KNOWN;
      d.len  = n;
      d.dash = p;
      return d;
   endfunction

   // uppercase ASCII to Morse pattern
   function automatic desc_type morse_lookup(input logic [7:0] ch);
      desc_type d;
      d.kind = KIND_UNKNOWN;
      d.len  = '0;
      d.dash = '0;
      case (ch)
         "A": d = known(3'd2, 6'b010000);
         "B": d = known(3'd4, 6'b100000);
         "C": d = known(3'd4, 6'b101000);
         "D": d = known(3'd3, 6'b100000);
         "E": d = known(3'd1, 6'b000000);
         "F": d = known(3'd4, 6'b001000);
         "G": d = known(3'd3, 6'b110000);
         "H": d = known(3'd4, 6'b000000);
         "I": d = known(3'd2, 6'b000000);
         "J": d = known(3'd4, 6'b011100);
         "K": d = known(3'd3, 6'b101000);
         "L": d = known(3'd4, 6'b010000);
         "M": d = known(3'd2, 6'b110000);
         "N": d = known(3'd2, 6'b100000);
         "O": d = known(3'd3, 6'b111000);
         "P": d = known(3'd4, 6'b011000);
         "Q": d = known(3'd4, 6'b110100);
         "R": d = known(3'd3, 6'b010000);
         "S": d = known(3'd3, 6'b000000);
         "T": d = known(3'd1, 6'b100000);
         "U": d = known(3'd3, 6'b001000);
         "V": d = known(3'd4, 6'b000100);
         "W": d = known(3'd3, 6'b011000);
         "X": d = known(3'd4, 6'b100100);
         "Y": d = known(3'd4, 6'b101100);
         "Z": d = known(3'd4, 6'b110000);
         "0": d = known(3'd5, 6'b111110);
         "1": d = known(3'd5, 6'b011110);
         "2": d = known(3'd5, 6'b001110);
         "3": d = known(3'd5, 6'b000110);
         "4": d = known(3'd5, 6'b000010);
         "5": d = known(3'd5, 6'b000000);
         "6": d = known(3'd5, 6'b100000);
         "7": d = known(3'd5, 6'b110000);
         "8": d = known(3'd5, 6'b111000);
         "9": d = known(3'd5, 6'b111100);
         ".": d = known(3'd6, 6'b010101);
         ",": d = known(3'd6, 6'b110011);
         "?": d = known(3'd6, 6'b001100);
         "/": d = known(3'd5, 6'b100100);
         "=": d = known(3'd5, 6'b100010);
         "+": d = known(3'd5, 6'b010100);
         "-": d = known(3'd6, 6'b100001);
         ":": d = known(3'd6, 6'b111000);
         "'": d = known(3'd6, 6'b011110);
         "(": d = known(3'd5, 6'b101100);
         ")": d = known(3'd6, 6'b101101);
         "@": d = known(3'd6, 6'b011010);
         default: d.kind = KIND_UNKNOWN;
      endcase
      return d;
   endfunction

   // gap shortened by the compensation, never below 1 ms
   function automatic logic [DUR_W-1:0] minus_comp(input logic [11:0] ms,
                                                   input logic [COMP_W-1:0] comp);
      logic [COMP_W-1:0] wide;
      wide = {4'b0, ms};
      if (wide > comp) begin
         return {1'b0, wide - comp};
      end else begin
         return {{(DUR_W-1){1'b0}}, 1'b1};
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mkf_timing.sv
// ----------------------------------------------------------------------------
// Morse keyer timing unit
// Clamps the speeds and derives dot and Farnsworth unit lengths in a
// four-stage pipeline; flags them stale after reset and after a write until a settle counter runs out.
// ----------------------------------------------------------------------------
`default_nettype none

module mkf_timing (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         cfg_write,
   input  wire logic [mkf_pkg::WPM_W-1:0]    char_speed_wpm,
   input  wire logic [mkf_pkg::WPM_W-1:0]    effective_speed_wpm,
   output mkf_pkg::timing_type               timing
);

   logic [mkf_pkg::WPM_W-1:0]  c_wpm, s_lo, s_wpm, c_off, s_off;
   logic [mkf_pkg::IDX_W-1:0]  ci_ff, ci_in, si_ff, si_in;
   logic [mkf_pkg::DOT_W-1:0]  dot2_ff, dot2_in, dot3_ff, dot4_ff;
   logic [mkf_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic [mkf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [mkf_pkg::UNIT_W-1:0] unit_ff, unit_in, su;
   logic [2:0]                 settle_ff, settle_in;

   // stage 1: clamp
   always_comb begin
      if (char_speed_wpm < mkf_pkg::WPM_MIN) begin
         c_wpm = mkf_pkg::WPM_MIN;
      end else if (char_speed_wpm > mkf_pkg::WPM_MAX) begin
         c_wpm = mkf_pkg::WPM_MAX;
      end else begin
         c_wpm = char_speed_wpm;
      end
      s_lo  = (effective_speed_wpm < mkf_pkg::WPM_MIN) ? mkf_pkg::WPM_MIN
                                                        : effective_speed_wpm;
      s_wpm = (s_lo > c_wpm) ? c_wpm : s_lo;
      c_off = c_wpm - mkf_pkg::WPM_MIN;
      s_off = s_wpm - mkf_pkg::WPM_MIN;
      ci_in = c_off[mkf_pkg::IDX_W-1:0];
      si_in = s_off[mkf_pkg::IDX_W-1:0];
   end

   // stage 2: table reads; difference is zero when eff equals char speed
   always_comb begin
      dot2_in = mkf_pkg::DOT_TAB[ci_ff];
      if (si_ff < ci_ff) begin
         diff_in = mkf_pkg::SIXTY_TAB[si_ff] - {1'b0, mkf_pkg::T37_TAB[ci_ff]};
      end else begin
         diff_in = '0;
      end
   end

   // stage 3: divide by 19 through the reciprocal
   assign prod_in = {{(mkf_pkg::PROD_W-mkf_pkg::DIFF_W){1'b0}}, diff_ff}
                  * {{(mkf_pkg::PROD_W-mkf_pkg::DIFF_W){1'b0}}, mkf_pkg::RECIP_19};

   // stage 4: unit never below one dot
   always_comb begin
      su      = prod_ff[mkf_pkg::RECIP_SHIFT +: mkf_pkg::UNIT_W];
      unit_in = (su > {2'b0, dot3_ff}) ? su : {2'b0, dot3_ff};
   end

   always_comb begin
      if (cfg_write) begin
         settle_in = mkf_pkg::SETTLE_CYCLES;
      end else if (settle_ff != 3'd0) begin
         settle_in = settle_ff - 3'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= mkf_pkg::SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff   <= ci_in;
      si_ff   <= si_in;
      dot2_ff <= dot2_in;
      diff_ff <= diff_in;
      dot3_ff <= dot2_ff;
      prod_ff <= prod_in;
      dot4_ff <= dot3_ff;
      unit_ff <= unit_in;
   end

   assign timing.ok   = (settle_ff == 3'd0);
   assign timing.dot  = dot4_ff;
   assign timing.unit = unit_ff;

endmodule

`default_nettype wire

FILE: rtl/mkf_front.sv
// ----------------------------------------------------------------------------
// Morse keyer front end
// Takes one character word, folds case, classifies it and pushes a pattern
// descriptor into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mkf_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [7:0]         req_character,
   input  wire logic               timing_ok,
   input  wire logic               q_full,
   output      logic               push,
   output      mkf_pkg::desc_type  push_desc
);

   logic       front_valid_ff, front_valid_in;
   logic [7:0] char_ff;
   logic [7:0] folded;
   logic       accept;

   assign req_stall = !timing_ok || (front_valid_ff && q_full);
   assign accept    = req_valid && !req_stall;
   assign push      = front_valid_ff && !q_full;

   always_comb begin
      if (char_ff >= mkf_pkg::LOWER_A && char_ff <= mkf_pkg::LOWER_Z) begin
         folded = char_ff - mkf_pkg::CASE_OFFSET;
      end else begin
         folded = char_ff;
      end
      push_desc = mkf_pkg::morse_lookup(folded);
      if (char_ff == mkf_pkg::ASCII_SPACE) begin
         push_desc.kind = mkf_pkg::KIND_SPACE;
      end
   end

   always_comb begin
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_character;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mkf_queue.sv
// ----------------------------------------------------------------------------
// Morse keyer descriptor queue
// Small FIFO of pattern descriptors between front end and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mkf_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire mkf_pkg::desc_type  push_desc,
   input  wire logic               pop,
   output      mkf_pkg::desc_type  pop_desc,
   output      logic               full,
   output      logic               empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mkf_pkg::desc_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_desc = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mkf_back.sv
// ----------------------------------------------------------------------------
// Morse keyer segment sequencer
// Walks one descriptor and emits its key-down and key-up segments, one per
// cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mkf_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   output      logic                          pop,
   input  wire mkf_pkg::desc_type             q_desc,
   input  wire mkf_pkg::timing_type           timing,
   input  wire logic [mkf_pkg::COMP_W-1:0]    key_comp_ms,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_key_down,
   output      logic [mkf_pkg::DUR_W-1:0]     rsp_duration_ms,
   output      logic                          rsp_last_segment
);

   mkf_pkg::back_state_type              st_ff, st_in;
   mkf_pkg::desc_type                    desc_ff, desc_in;
   logic [mkf_pkg::ELEM_W-1:0]           idx_ff, idx_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 key_ff, last_ff;
   logic [mkf_pkg::DUR_W-1:0]            dur_ff;

   logic                                 out_free, emit;
   logic                                 seg_key, seg_last;
   logic [mkf_pkg::DUR_W-1:0]            seg_dur;
   logic                                 elem_dash;
   logic [9:0]                           on_ms;
   logic [11:0]                          unit3, unit4;
   logic [mkf_pkg::DUR_W-1:0]            mark_dur, gap_dur, end_dur, word_dur;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      elem_dash = desc_ff.dash[3'd5 - idx_ff];
      on_ms     = elem_dash ? ({1'b0, timing.dot, 1'b0} + {2'b0, timing.dot})
                            : {2'b0, timing.dot};
      mark_dur  = {7'b0, on_ms} + {1'b0, key_comp_ms};
      gap_dur   = mkf_pkg::minus_comp({4'b0, timing.dot}, key_comp_ms);
      unit3     = {1'b0, timing.unit, 1'b0} + {2'b0, timing.unit};
      unit4     = {timing.unit, 2'b0};
      end_dur   = mkf_pkg::minus_comp(unit3, key_comp_ms);
      word_dur  = {5'b0, unit4};
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         mkf_pkg::BK_IDLE: begin
            if (!q_empty) begin
               case (q_desc.kind)
                  mkf_pkg::KIND_KNOWN: st_in = mkf_pkg::BK_MARK;
                  mkf_pkg::KIND_SPACE: st_in = mkf_pkg::BK_WORD;
                  default:             st_in = mkf_pkg::BK_END;
               endcase
            end
         end
         mkf_pkg::BK_MARK: begin
            if (out_free) begin
               st_in = (idx_ff + 3'd1 < desc_ff.len) ? mkf_pkg::BK_SPACE
                                                      : mkf_pkg::BK_END;
            end
         end
         mkf_pkg::BK_SPACE: begin
            if (out_free) begin
               st_in = mkf_pkg::BK_MARK;
            end
         end
         mkf_pkg::BK_END, mkf_pkg::BK_WORD: begin
            if (out_free) begin
               st_in = mkf_pkg::BK_IDLE;
            end
         end
         default: st_in = mkf_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop      = 1'b0;
      emit     = 1'b0;
      seg_key  = 1'b0;
      seg_last = 1'b0;
      seg_dur  = mark_dur;
      desc_in  = desc_ff;
      idx_in   = idx_ff;
      case (st_ff)
         mkf_pkg::BK_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               desc_in = q_desc;
               idx_in  = '0;
            end
         end
         mkf_pkg::BK_MARK: begin
            emit    = out_free;
            seg_key = 1'b1;
         end
         mkf_pkg::BK_SPACE: begin
            emit    = out_free;
            seg_dur = gap_dur;
            if (out_free) begin
               idx_in = idx_ff + 3'd1;
            end
         end
         mkf_pkg::BK_END: begin
            emit     = out_free;
            seg_dur  = end_dur;
            seg_last = 1'b1;
         end
         mkf_pkg::BK_WORD: begin
            emit     = out_free;
            seg_dur  = word_dur;
            seg_last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= mkf_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      idx_ff  <= idx_in;
      if (emit) begin
         key_ff  <= seg_key;
         dur_ff  <= seg_dur;
         last_ff <= seg_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_down     = key_ff;
   assign rsp_duration_ms  = dur_ff;
   assign rsp_last_segment = last_ff;

endmodule

`default_nettype wire

FILE: rtl/morse_keyer_farnsworth.sv
// ----------------------------------------------------------------------------
// Morse keyer with Farnsworth timing
// Turns ASCII character words into keyed segments with millisecond lengths.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// req      req_valid/req_stall   req_character[7:0]
// rsp      rsp_valid/rsp_stall   rsp_key_down, rsp_duration_ms[16:0], rsp_last_segment
// csr      csr_valid/csr_ready   csr_index[1:0], csr_wdata[15:0]
//
// A character is registered in the front end and pushed into the queue; the
// sequencer pops it, loads its descriptor and then emits its segments in
// turn. The sequencer sets the rate. After reset and after every register
// write the input stalls while the timing pipeline refills. Reset is
// synchronous and clears control. A stalled result holds in the output
// register; the queue takes up to QUEUE_DEPTH descriptors meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_keyer_farnsworth #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [7:0]                    req_character,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_key_down,
   output      logic [mkf_pkg::DUR_W-1:0]     rsp_duration_ms,
   output      logic                          rsp_last_segment,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [mkf_pkg::COMP_W-1:0]    csr_wdata
);

   logic [mkf_pkg::WPM_W-1:0]  char_speed_ff, eff_speed_ff;
   logic [mkf_pkg::COMP_W-1:0] key_comp_ff;
   logic                       csr_write;

   mkf_pkg::timing_type        timing;
   mkf_pkg::desc_type          push_desc, pop_desc;
   logic                       push, pop, q_full, q_empty;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_speed_ff <= mkf_pkg::CHAR_SPEED_RST;
         eff_speed_ff  <= mkf_pkg::EFF_SPEED_RST;
         key_comp_ff   <= mkf_pkg::KEY_COMP_RST;
      end else if (csr_write) begin
         case (csr_index)
            mkf_pkg::CSR_CHAR_SPEED: char_speed_ff <= csr_wdata[mkf_pkg::WPM_W-1:0];
            mkf_pkg::CSR_EFF_SPEED:  eff_speed_ff  <= csr_wdata[mkf_pkg::WPM_W-1:0];
            mkf_pkg::CSR_KEY_COMP:   key_comp_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   mkf_timing u_timing (
      .clock               (clock),
      .reset               (reset),
      .cfg_write           (csr_write),
      .char_speed_wpm      (char_speed_ff),
      .effective_speed_wpm (eff_speed_ff),
      .timing              (timing)
   );

   mkf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .timing_ok     (timing.ok),
      .q_full        (q_full),
      .push          (push),
      .push_desc     (push_desc)
   );

   mkf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   mkf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .pop              (pop),
      .q_desc           (pop_desc),
      .timing           (timing),
      .key_comp_ms      (key_comp_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_down     (rsp_key_down),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

`default_nettype wire

FILE: rtl/mkf_checker.sv
// ----------------------------------------------------------------------------
// Morse keyer port checker
// Watches the keyer's ports for ordering and hold rules over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "morse_keyer_farnsworth_defines.svh"

module mkf_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic                       rsp_key_down,
   input wire logic [mkf_pkg::DUR_W-1:0]  rsp_duration_ms,
   input wire logic                       rsp_last_segment,
   input wire logic                       csr_valid,
   input wire logic                       csr_ready
);

   logic       req_acc, rsp_acc, rsp_done;
   logic [7:0] open_ff, open_in;
   logic       prev_down_ff, prev_down_in;

   assign req_acc  = req_valid && !req_stall;
   assign rsp_acc  = rsp_valid && !rsp_stall;
   assign rsp_done = rsp_acc && rsp_last_segment;

   // characters accepted whose final segment is still out
   always_comb begin
      open_in = open_ff;
      if (req_acc && !rsp_done) begin
         open_in = open_ff + 8'd1;
      end else if (rsp_done && !req_acc) begin
         open_in = open_ff - 8'd1;
      end
   end

   assign prev_down_in = rsp_acc ? rsp_key_down : prev_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= '0;
         prev_down_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         prev_down_ff <= prev_down_in;
      end
   end

   `MKF_ASSERT_NEXT(a_csr_stalls_req, clock, reset, csr_valid && csr_ready, req_stall, "input taken right after a register write")
   `MKF_ASSERT_SAME(a_rsp_has_source, clock, reset, rsp_valid, open_ff != 8'd0, "segment with no open character")
   `MKF_ASSERT_SAME(a_no_double_mark, clock, reset, rsp_valid && rsp_key_down, !prev_down_ff, "two key-down segments in a row")
   `MKF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_duration_ms) && $stable(rsp_key_down) && $stable(rsp_last_segment), "stalled result word changed")

endmodule

bind morse_keyer_farnsworth mkf_checker u_mkf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_key_down     (rsp_key_down),
   .rsp_duration_ms  (rsp_duration_ms),
   .rsp_last_segment (rsp_last_segment),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready)
);

`default_nettype wire
